// ----- design/kst_pkg.sv -----
package kst_pkg;

   localparam int unsigned VERTEX_W         = 9;
   localparam int unsigned ID_W             = 16;
   localparam int unsigned WEIGHT_W         = 16;
   localparam int unsigned SUM_W            = 25;
   localparam int unsigned COUNT_W          = 9;
   localparam int unsigned STATUS_W         = 2;
   localparam int unsigned MAX_VERTICES_DEF = 512;
   localparam int unsigned QUEUE_DEPTH      = 2;

   localparam logic [VERTEX_W-1:0] VERTEX_COUNT_RESET = VERTEX_W'(511);
   localparam logic [SUM_W-1:0]    SUM_MAX            = '1;
   localparam logic [COUNT_W-1:0]  COUNT_MAX          = '1;

   typedef enum logic [STATUS_W-1:0] {
      ST_REJECT   = 2'd0,
      ST_TAKEN    = 2'd1,
      ST_COMPLETE = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_CLEAR,
      BK_CHECK,
      BK_READ_TO,
      BK_COMPARE,
      BK_WALK,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic [ID_W-1:0]     edge_id;
      logic [VERTEX_W-1:0] from_vertex;
      logic [VERTEX_W-1:0] to_vertex;
      logic [WEIGHT_W-1:0] edge_weight;
      logic                first_edge;
      logic                last_edge;
      logic                range_ok;
   } edge_item_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

   function automatic logic vertex_ok(input logic [VERTEX_W-1:0] v,
                                      input logic [VERTEX_W-1:0] count,
                                      input int unsigned max_vertices);
      return (v != '0) && (v <= count) && (32'(v) < max_vertices);
   endfunction

   function automatic logic [VERTEX_W-1:0] edges_needed(input logic [VERTEX_W-1:0] count);
      return (count > VERTEX_W'(1)) ? count - VERTEX_W'(1) : '0;
   endfunction

endpackage

// ----- design/kst_req_if.sv -----
interface kst_req_if;
   logic                            valid;
   logic                            ready;
   logic [kst_pkg::ID_W-1:0]        edge_id;
   logic [kst_pkg::VERTEX_W-1:0]    from_vertex;
   logic [kst_pkg::VERTEX_W-1:0]    to_vertex;
   logic [kst_pkg::WEIGHT_W-1:0]    edge_weight;
   logic                            first_edge;
   logic                            last_edge;

   modport source (output valid, edge_id, from_vertex, to_vertex, edge_weight,
                   first_edge, last_edge, input ready);
   modport sink (input valid, edge_id, from_vertex, to_vertex, edge_weight,
                 first_edge, last_edge, output ready);
endinterface

// ----- design/kst_rsp_if.sv -----
interface kst_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [kst_pkg::STATUS_W-1:0]    status;
   logic [kst_pkg::ID_W-1:0]        taken_id;
   logic [kst_pkg::SUM_W-1:0]       total_weight;
   logic [kst_pkg::COUNT_W-1:0]     taken_count;
   logic                            tree_complete;
   logic                            graph_end;

   modport source (output valid, status, taken_id, total_weight, taken_count,
                   tree_complete, graph_end, input ready);
   modport sink (input valid, status, taken_id, total_weight, taken_count,
                 tree_complete, graph_end, output ready);
endinterface

// ----- design/kst_ram.sv -----
module kst_ram #(
   parameter int unsigned WIDTH = 9,
   parameter int unsigned DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/kst_front.sv -----
module kst_front #(
   parameter int unsigned MAX_VERTICES = kst_pkg::MAX_VERTICES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   kst_req_if.sink                       req_if,
   input  logic [kst_pkg::VERTEX_W-1:0]  vertex_count,
   input  kst_pkg::back_status_type      back_status,
   input  logic                          pop,
   output logic                          head_valid,
   output kst_pkg::edge_item_type        head
);

   localparam int unsigned PTR_W = $clog2(kst_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(kst_pkg::QUEUE_DEPTH + 1);

   kst_pkg::edge_item_type entry_ff [kst_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             take;
   kst_pkg::edge_item_type incoming;

   assign req_if.ready = (count_ff != CNT_W'(kst_pkg::QUEUE_DEPTH)) && !back_status.init_busy;
   assign push = req_if.valid && req_if.ready;
   assign head_valid = (count_ff != '0);
   assign take = pop && head_valid;
   assign head = entry_ff[rd_ptr_ff];

   always_comb begin
      incoming.edge_id     = req_if.edge_id;
      incoming.from_vertex = req_if.from_vertex;
      incoming.to_vertex   = req_if.to_vertex;
      incoming.edge_weight = req_if.edge_weight;
      incoming.first_edge  = req_if.first_edge;
      incoming.last_edge   = req_if.last_edge;
      incoming.range_ok    = kst_pkg::vertex_ok(req_if.from_vertex, vertex_count, MAX_VERTICES)
                             && kst_pkg::vertex_ok(req_if.to_vertex, vertex_count, MAX_VERTICES);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(kst_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(kst_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

// ----- design/kst_back.sv -----
module kst_back #(
   parameter int unsigned MAX_VERTICES = kst_pkg::MAX_VERTICES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [kst_pkg::VERTEX_W-1:0]  vertex_count,
   input  logic                          head_valid,
   input  kst_pkg::edge_item_type        head,
   output logic                          pop,
   output kst_pkg::back_status_type      back_status,
   kst_rsp_if.source                     rsp_if
);

   localparam int unsigned AW = $clog2(MAX_VERTICES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

   kst_pkg::back_state_type state_ff, state_in;
   kst_pkg::edge_item_type  item_ff, item_in;
   logic [AW-1:0]                 clr_ff, clr_in;
   logic [AW-1:0]                 walk_ff, walk_in;
   logic [AW-1:0]                 keep_ff, keep_in;
   logic [AW-1:0]                 drop_ff, drop_in;
   logic [kst_pkg::COUNT_W-1:0]   edges_ff, edges_in;
   logic [kst_pkg::SUM_W-1:0]     sum_ff, sum_in;
   kst_pkg::status_type           status_ff, status_in;
   logic [kst_pkg::ID_W-1:0]      taken_id_ff, taken_id_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   kst_pkg::status_type           rsp_status_ff;
   logic [kst_pkg::ID_W-1:0]      rsp_taken_id_ff;
   logic [kst_pkg::SUM_W-1:0]     rsp_total_ff;
   logic [kst_pkg::COUNT_W-1:0]   rsp_count_ff;
   logic                          rsp_complete_ff;
   logic                          rsp_end_ff;

   logic                          ram_we;
   logic [AW-1:0]                 ram_waddr;
   logic [AW-1:0]                 ram_wdata;
   logic [AW-1:0]                 ram_raddr;
   logic [AW-1:0]                 ram_rdata;

   logic                          tree_done;
   logic [AW-1:0]                 top_vertex;
   logic                          out_free;
   logic                          emit;
   logic [kst_pkg::SUM_W:0]       sum_wide;

   kst_ram #(
      .WIDTH (AW),
      .DEPTH (MAX_VERTICES)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign tree_done  = edges_ff >= kst_pkg::edges_needed(vertex_count);
   assign top_vertex = (32'(vertex_count) < MAX_VERTICES) ? AW'(vertex_count) : LAST_ADDR;
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign sum_wide   = {1'b0, sum_ff} + (kst_pkg::SUM_W + 1)'(item_ff.edge_weight);
   assign back_status.init_busy = (state_ff == kst_pkg::BK_INIT);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kst_pkg::BK_INIT: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = kst_pkg::BK_IDLE;
            end
         end
         kst_pkg::BK_IDLE: begin
            if (head_valid) begin
               state_in = head.first_edge ? kst_pkg::BK_CLEAR : kst_pkg::BK_CHECK;
            end
         end
         kst_pkg::BK_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = kst_pkg::BK_CHECK;
            end
         end
         kst_pkg::BK_CHECK: begin
            state_in = (tree_done || !item_ff.range_ok) ? kst_pkg::BK_EMIT
                                                        : kst_pkg::BK_READ_TO;
         end
         kst_pkg::BK_READ_TO: begin
            state_in = kst_pkg::BK_COMPARE;
         end
         kst_pkg::BK_COMPARE: begin
            state_in = (keep_ff == ram_rdata) ? kst_pkg::BK_EMIT : kst_pkg::BK_WALK;
         end
         kst_pkg::BK_WALK: begin
            if (walk_ff == top_vertex) begin
               state_in = kst_pkg::BK_EMIT;
            end
         end
         kst_pkg::BK_EMIT: begin
            if (out_free) begin
               state_in = kst_pkg::BK_IDLE;
            end
         end
         default: state_in = kst_pkg::BK_INIT;
      endcase
   end

   always_comb begin
      item_in     = item_ff;
      clr_in      = clr_ff;
      walk_in     = walk_ff;
      keep_in     = keep_ff;
      drop_in     = drop_ff;
      edges_in    = edges_ff;
      sum_in      = sum_ff;
      status_in   = status_ff;
      taken_id_in = taken_id_ff;
      pop         = 1'b0;
      emit        = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = clr_ff;
      ram_wdata   = clr_ff;
      ram_raddr   = AW'(item_ff.from_vertex);
      unique case (state_ff)
         kst_pkg::BK_INIT,
         kst_pkg::BK_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         kst_pkg::BK_IDLE: begin
            if (head_valid) begin
               pop     = 1'b1;
               item_in = head;
               clr_in  = '0;
               if (head.first_edge) begin
                  edges_in = '0;
                  sum_in   = '0;
               end
            end
         end
         kst_pkg::BK_CHECK: begin
            taken_id_in = '0;
            status_in   = tree_done ? kst_pkg::ST_COMPLETE : kst_pkg::ST_RANGE;
         end
         kst_pkg::BK_READ_TO: begin
            ram_raddr = AW'(item_ff.to_vertex);
            keep_in   = ram_rdata;
         end
         kst_pkg::BK_COMPARE: begin
            drop_in   = ram_rdata;
            ram_raddr = AW'(1);
            walk_in   = AW'(1);
            if (keep_ff == ram_rdata) begin
               status_in = kst_pkg::ST_REJECT;
            end else begin
               status_in   = kst_pkg::ST_TAKEN;
               taken_id_in = item_ff.edge_id;
               sum_in      = sum_wide[kst_pkg::SUM_W] ? kst_pkg::SUM_MAX
                                                      : sum_wide[kst_pkg::SUM_W-1:0];
               if (edges_ff != kst_pkg::COUNT_MAX) begin
                  edges_in = edges_ff + 1'b1;
               end
            end
         end
         kst_pkg::BK_WALK: begin
            ram_raddr = walk_ff + 1'b1;
            walk_in   = walk_ff + 1'b1;
            if (ram_rdata == drop_ff) begin
               ram_we    = 1'b1;
               ram_waddr = walk_ff;
               ram_wdata = keep_ff;
            end
         end
         kst_pkg::BK_EMIT: begin
            emit = out_free;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kst_pkg::BK_INIT;
         clr_ff       <= '0;
         edges_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         edges_ff     <= edges_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      walk_ff     <= walk_in;
      keep_ff     <= keep_in;
      drop_ff     <= drop_in;
      status_ff   <= status_in;
      taken_id_ff <= taken_id_in;
      if (emit) begin
         rsp_status_ff   <= status_ff;
         rsp_taken_id_ff <= taken_id_ff;
         rsp_total_ff    <= sum_ff;
         rsp_count_ff    <= edges_ff;
         rsp_complete_ff <= tree_done;
         rsp_end_ff      <= item_ff.last_edge;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.taken_id      = rsp_taken_id_ff;
   assign rsp_if.total_weight  = rsp_total_ff;
   assign rsp_if.taken_count   = rsp_count_ff;
   assign rsp_if.tree_complete = rsp_complete_ff;
   assign rsp_if.graph_end     = rsp_end_ff;

endmodule

// ----- design/kruskal_spanning_tree.sv -----
// Channel   Direction  Carries
// req_if    in         one edge: id, both end vertices, weight, first and last marks
// rsp_if    out        one result per edge: status, id, running sum and count, flags
// csr_*     in         vertex_count write, taken at once, no read-back
//
// An edge not taken runs the check, label read, compare and emit states in the back
// part, only check and emit when the tree is already complete or a vertex is out of
// range; a taken edge adds a relabel walk over vertices 1 to min(vertex_count,
// MAX_VERTICES-1) on the label RAM's single read port. A first-marked request adds a
// clearing pass over the whole RAM; after reset that pass runs with req_if.ready low.
// A two-request queue and the output register let each side stall on its own.
module kruskal_spanning_tree #(
   parameter int unsigned MAX_VERTICES = kst_pkg::MAX_VERTICES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   kst_req_if.sink                       req_if,
   kst_rsp_if.source                     rsp_if,
   input  logic                          csr_wr_en,
   input  logic [kst_pkg::VERTEX_W-1:0]  csr_wr_data
);

   logic [kst_pkg::VERTEX_W-1:0] vertex_count_ff, vertex_count_in;
   kst_pkg::back_status_type     back_status;
   kst_pkg::edge_item_type       head;
   logic                         head_valid;
   logic                         pop;

   assign vertex_count_in = csr_wr_en ? csr_wr_data : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= kst_pkg::VERTEX_COUNT_RESET;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   kst_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .vertex_count (vertex_count_ff),
      .back_status  (back_status),
      .pop          (pop),
      .head_valid   (head_valid),
      .head         (head)
   );

   kst_back #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .vertex_count (vertex_count_ff),
      .head_valid   (head_valid),
      .head         (head),
      .pop          (pop),
      .back_status  (back_status),
      .rsp_if       (rsp_if)
   );

`ifndef SYNTH
   a_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      back_status.init_busy |-> !req_if.ready)
      else $error("request accepted during label clearing pass");

   a_taken_has_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == kst_pkg::ST_TAKEN) |-> (rsp_if.taken_count != '0))
      else $error("taken edge with zero taken count");

   a_id_only_when_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != kst_pkg::ST_TAKEN) |-> (rsp_if.taken_id == '0))
      else $error("edge id echoed on an edge not taken");

   a_pop_only_when_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");
`endif

endmodule
